@@ hw/rtl/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define PPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PPS_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/pps_pkg.sv @@
// types, constants and helpers of the payload power sequencer
package pps_pkg;

    localparam int RAIL_COUNT_DEF = 11;
    localparam int RAIL_W         = 11;
    localparam int ADC_W          = 12;
    localparam int PRESS_W        = 16;
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 16;

    localparam logic [ADC_W-1:0]   THRESHOLD_RST  = 12'h9B2;
    localparam logic [PRESS_W-1:0] LONG_PRESS_RST = 16'd200;
    localparam logic [PRESS_W-1:0] PRESS_MAX      = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_THRESHOLD  = 1'b0,
        CFG_LONG_PRESS = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OFF        = 3'd0,
        ST_GOOD_WAIT  = 3'd1,
        ST_SETUP      = 3'd2,
        ST_ON         = 3'd3,
        ST_SWITCH_OFF = 3'd4,
        ST_QUIESCED   = 3'd5,
        ST_RESET      = 3'd6
    } seq_state_t;

    typedef enum logic [1:0] {
        RUN_NONE = 2'd0,
        RUN_UP   = 2'd1,
        RUN_DOWN = 2'd2
    } run_t;

    typedef struct packed {
        logic [ADC_W-1:0] adc_sample;
        logic             converters_good;
        logic             button_level;
        logic             quiesce_msg;
        logic             cold_reset_msg;
        logic             reboot_msg;
        logic             clock_config_msg;
        logic             clock_write_ok;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        payload_state;
        logic [RAIL_W-1:0] rail_enables;
        logic              last_of_run;
        logic              fpga_reset_n;
        logic              fpga_init_b;
        logic              fpga_program_b;
        logic              fmc_power_good;
        logic              soft_reset_pulse;
        logic              quiesced_event;
        logic              clear_backend_fault;
        logic              clock_write_request;
    } out_item_t;

    typedef struct packed {
        logic fmc_power_good;
        logic prog_b;
        logic init_b;
        logic reset_n;
    } pins_t;

    typedef struct packed {
        logic soft_reset_pulse;
        logic quiesced_event;
        logic clear_backend_fault;
        logic clock_write_request;
    } events_t;

    // one tick's outcome handed from the sequencer to the result stage
    typedef struct packed {
        run_t              run;
        logic [RAIL_W-1:0] start_mask;
        logic [2:0]        payload_state;
        pins_t             pins;
        events_t           events;
    } step_t;

    // single rail bit, rails past the mask width drop out
    function automatic logic [RAIL_W-1:0] rail_bit(input logic [4:0] idx);
        logic [RAIL_W-1:0] m;
        m = '0;
        for (int i = 0; i < RAIL_W; i++)
        begin
            if (idx == 5'(i))
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

    // all rails that a full switch run touches
    function automatic logic [RAIL_W-1:0] rail_span(input int count);
        logic [RAIL_W-1:0] m;
        m = '0;
        for (int i = 0; i < RAIL_W; i++)
        begin
            if (i < count)
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

@@ hw/rtl/pps_core.sv @@
// input register, configuration registers and power sequencer step logic
module pps_core #(
    parameter int RAIL_COUNT = pps_pkg::RAIL_COUNT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [pps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  pps_pkg::in_item_t                   in_data,
    input  logic                                load_ok,
    output logic                                step_valid,
    output pps_pkg::step_t                      step
);

    localparam logic [pps_pkg::RAIL_W-1:0] SPAN = pps_pkg::rail_span(RAIL_COUNT);

    logic [pps_pkg::ADC_W-1:0]   threshold_reg;
    logic [pps_pkg::PRESS_W-1:0] long_press_reg;

    logic                        in_valid_reg;
    pps_pkg::in_item_t           in_data_reg;

    pps_pkg::seq_state_t         state_reg, state_next, st_mid;
    logic                        quiesce_reg, quiesce_next, quiesce_mid;
    logic                        button_prev_reg;
    logic                        lock_reg, lock_next, lock_mid;
    logic [pps_pkg::PRESS_W-1:0] press_reg, press_next;
    logic [pps_pkg::RAIL_W-1:0]  rail_reg, rail_next;
    pps_pkg::pins_t              pins_reg, pins_next;

    logic                        load;
    logic                        supply_good;
    logic                        fall;
    logic                        long_press;
    logic                        soft_fire;
    pps_pkg::run_t               run;
    pps_pkg::events_t            events;

    assign load       = in_valid_reg && load_ok;
    assign in_ready   = !in_valid_reg || load;
    assign step_valid = in_valid_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= pps_pkg::THRESHOLD_RST;
            long_press_reg <= pps_pkg::LONG_PRESS_RST;
        end
        else if (cfg_write)
        begin
            case (pps_pkg::cfg_reg_t'(cfg_index))
                pps_pkg::CFG_THRESHOLD:  threshold_reg  <= cfg_data[pps_pkg::ADC_W-1:0];
                pps_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    // front button long press
    always_comb
    begin
        fall = !in_data_reg.button_level && button_prev_reg;
        if (fall)
        begin
            press_next = '0;
            lock_mid   = 1'b0;
        end
        else
        begin
            press_next = (press_reg != pps_pkg::PRESS_MAX) ? press_reg + 1'b1 : press_reg;
            lock_mid   = lock_reg;
        end
        long_press = (press_next > long_press_reg) && !lock_mid && !in_data_reg.button_level;
        lock_next  = lock_mid || long_press;
        soft_fire  = long_press || in_data_reg.reboot_msg;
    end

    // message handling ahead of the state update
    always_comb
    begin
        supply_good = in_data_reg.adc_sample > threshold_reg;
        st_mid      = in_data_reg.cold_reset_msg ? pps_pkg::ST_RESET : state_reg;
        if (in_data_reg.quiesce_msg)
        begin
            quiesce_mid = (state_reg != pps_pkg::ST_QUIESCED);
        end
        else
        begin
            quiesce_mid = quiesce_reg;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = st_mid;
        case (st_mid)
            pps_pkg::ST_OFF:
            begin
                if (supply_good)
                begin
                    state_next = pps_pkg::ST_GOOD_WAIT;
                end
            end
            pps_pkg::ST_GOOD_WAIT:
            begin
                if (quiesce_mid || !supply_good)
                begin
                    state_next = pps_pkg::ST_SWITCH_OFF;
                end
                else if (in_data_reg.converters_good)
                begin
                    state_next = pps_pkg::ST_SETUP;
                end
            end
            pps_pkg::ST_SETUP:
            begin
                if (in_data_reg.clock_write_ok)
                begin
                    state_next = pps_pkg::ST_ON;
                end
            end
            pps_pkg::ST_ON:
            begin
                if (quiesce_mid || !supply_good || !in_data_reg.converters_good)
                begin
                    state_next = pps_pkg::ST_SWITCH_OFF;
                end
            end
            pps_pkg::ST_SWITCH_OFF: state_next = pps_pkg::ST_QUIESCED;
            pps_pkg::ST_QUIESCED:
            begin
                if (!supply_good && !in_data_reg.converters_good)
                begin
                    state_next = pps_pkg::ST_OFF;
                end
            end
            pps_pkg::ST_RESET: state_next = pps_pkg::ST_OFF;
            default: state_next = st_mid;
        endcase
    end

    // sequencer outputs: pins, rail run and events
    always_comb
    begin
        pins_next    = pins_reg;
        pins_next.reset_n = pins_reg.reset_n || soft_fire;
        quiesce_next = quiesce_mid;
        run          = pps_pkg::RUN_NONE;
        events.soft_reset_pulse    = soft_fire;
        events.quiesced_event      = 1'b0;
        events.clear_backend_fault = 1'b0;
        events.clock_write_request =
            (in_data_reg.clock_config_msg && state_reg == pps_pkg::ST_ON) ||
            (st_mid == pps_pkg::ST_SETUP);
        case (st_mid)
            pps_pkg::ST_GOOD_WAIT:
            begin
                if (!in_data_reg.converters_good)
                begin
                    run = pps_pkg::RUN_UP;
                end
                events.clear_backend_fault = 1'b1;
                if (!quiesce_mid && supply_good && in_data_reg.converters_good)
                begin
                    pins_next.prog_b  = 1'b1;
                    pins_next.init_b  = 1'b1;
                    pins_next.reset_n = 1'b1;
                end
            end
            pps_pkg::ST_SETUP:
            begin
                pins_next.fmc_power_good = 1'b1;
            end
            pps_pkg::ST_SWITCH_OFF:
            begin
                pins_next             = '0;
                run                   = pps_pkg::RUN_DOWN;
                events.quiesced_event = quiesce_mid;
                quiesce_next          = 1'b0;
            end
            pps_pkg::ST_RESET:
            begin
                run = pps_pkg::RUN_DOWN;
            end
            default: ;
        endcase
    end

    // rail mask after the whole run
    always_comb
    begin
        case (run)
            pps_pkg::RUN_UP:   rail_next = rail_reg | SPAN;
            pps_pkg::RUN_DOWN: rail_next = rail_reg & ~SPAN;
            default:           rail_next = rail_reg;
        endcase
    end

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= pps_pkg::ST_OFF;
            quiesce_reg     <= 1'b0;
            button_prev_reg <= 1'b1;
            lock_reg        <= 1'b0;
            press_reg       <= '0;
            rail_reg        <= '0;
            pins_reg        <= '0;
        end
        else if (load)
        begin
            state_reg       <= state_next;
            quiesce_reg     <= quiesce_next;
            button_prev_reg <= in_data_reg.button_level;
            lock_reg        <= lock_next;
            press_reg       <= press_next;
            rail_reg        <= rail_next;
            pins_reg        <= pins_next;
        end
    end

    // step handed to the result stage
    always_comb
    begin
        step.run           = run;
        step.start_mask    = rail_reg;
        step.payload_state = 3'(state_next);
        step.pins          = pins_next;
        step.events        = events;
    end

endmodule

@@ hw/rtl/pps_emit.sv @@
// result register that plays out one result or a full rail step run
module pps_emit #(
    parameter int RAIL_COUNT = pps_pkg::RAIL_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step_valid,
    input  pps_pkg::step_t      step,
    output logic                load_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output pps_pkg::out_item_t  out_data
);

    localparam int CW = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1;
    localparam logic [CW-1:0] TOP_IDX = CW'(RAIL_COUNT - 1);

    logic                       out_valid_reg;
    pps_pkg::step_t             step_reg;
    logic [pps_pkg::RAIL_W-1:0] mask_reg, mask_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              remain_reg;
    logic                       last;
    logic                       take;
    logic                       load;

    assign last    = (remain_reg == '0);
    assign take    = out_valid_reg && out_ready;
    assign load_ok = !out_valid_reg || (take && last);
    assign load    = step_valid && load_ok;

    // next rail step within a run
    always_comb
    begin
        if (step_reg.run == pps_pkg::RUN_UP)
        begin
            idx_next  = idx_reg + 1'b1;
            mask_next = mask_reg | pps_pkg::rail_bit(5'(idx_next));
        end
        else
        begin
            idx_next  = idx_reg - 1'b1;
            mask_next = mask_reg & ~pps_pkg::rail_bit(5'(idx_next));
        end
    end

    // valid and beat count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            remain_reg    <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            remain_reg    <= (step.run == pps_pkg::RUN_NONE) ? '0 : TOP_IDX;
        end
        else if (take)
        begin
            if (last)
            begin
                out_valid_reg <= 1'b0;
            end
            else
            begin
                remain_reg <= remain_reg - 1'b1;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            step_reg <= step;
            case (step.run)
                pps_pkg::RUN_UP:
                begin
                    idx_reg  <= '0;
                    mask_reg <= step.start_mask | pps_pkg::rail_bit(5'd0);
                end
                pps_pkg::RUN_DOWN:
                begin
                    idx_reg  <= TOP_IDX;
                    mask_reg <= step.start_mask & ~pps_pkg::rail_bit(5'(TOP_IDX));
                end
                default:
                begin
                    idx_reg  <= '0;
                    mask_reg <= step.start_mask;
                end
            endcase
        end
        else if (take && !last)
        begin
            idx_reg  <= idx_next;
            mask_reg <= mask_next;
        end
    end

    // result fields, events ride on the final result only
    always_comb
    begin
        out_data.payload_state       = step_reg.payload_state;
        out_data.rail_enables        = mask_reg;
        out_data.last_of_run         = last;
        out_data.fpga_reset_n        = step_reg.pins.reset_n;
        out_data.fpga_init_b         = step_reg.pins.init_b;
        out_data.fpga_program_b      = step_reg.pins.prog_b;
        out_data.fmc_power_good      = step_reg.pins.fmc_power_good;
        out_data.soft_reset_pulse    = last && step_reg.events.soft_reset_pulse;
        out_data.quiesced_event      = last && step_reg.events.quiesced_event;
        out_data.clear_backend_fault = last && step_reg.events.clear_backend_fault;
        out_data.clock_write_request = last && step_reg.events.clock_write_request;
    end

    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/payload_power_sequencer_top.sv @@
// top level of the payload power sequencer
//
// channel   direction  handshake              payload
// cfg       in         cfg_write              cfg_index, cfg_data
// request   in         in_valid / in_ready    in_data   (pps_pkg::in_item_t)
// result    out        out_valid / out_ready  out_data  (pps_pkg::out_item_t)
//
// a request is held in the input register after its acceptance and enters the result
// register once that register can take it, which then offers its first result
// a request without a rail run gives one result; such requests flow one per cycle while
// results are taken; one that switches the converters gives RAIL_COUNT results, one per
// cycle while taken, and the next request waits, input stalled, in the input register
// reset clears the sequencer to no power with all rails and pins low
// a stalled result holds the request waiting in the input register
module payload_power_sequencer_top #(
    parameter int RAIL_COUNT = pps_pkg::RAIL_COUNT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [pps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  pps_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output pps_pkg::out_item_t              out_data
);

    logic           step_valid;
    logic           load_ok;
    pps_pkg::step_t step;

    // sequencer step logic
    pps_core #(
        .RAIL_COUNT (RAIL_COUNT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .load_ok    (load_ok),
        .step_valid (step_valid),
        .step       (step)
    );

    // result sequencing
    pps_emit #(
        .RAIL_COUNT (RAIL_COUNT)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_valid (step_valid),
        .step       (step),
        .load_ok    (load_ok),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

@@ hw/rtl/pps_checker.sv @@
// port checker for the payload power sequencer and its bind
`include "assert_macros.svh"

module pps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input pps_pkg::out_item_t out_data
);

    // a stalled result holds its payload
    `PPS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

    // events appear only on the final result of a run
    `PPS_ASSERT(a_events_last, !out_valid || out_data.last_of_run || (!out_data.soft_reset_pulse && !out_data.quiesced_event && !out_data.clear_backend_fault && !out_data.clock_write_request), "event on a non-final result")

    // a run continues without a gap after a non-final result
    `PPS_ASSERT_NEXT(a_run_gapless, out_valid && out_ready && !out_data.last_of_run, out_valid && out_data.payload_state == $past(out_data.payload_state), "rail run broken")

    // consecutive rail steps differ by at most one rail
    `PPS_ASSERT_NEXT(a_rail_step, out_valid && out_ready && !out_data.last_of_run, $countones(out_data.rail_enables ^ $past(out_data.rail_enables)) <= 1, "rail step moved several rails")

endmodule

bind payload_power_sequencer_top pps_checker u_pps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

@@ bench/payload_power_sequencer_top_test.sv @@
// testbench of the payload power sequencer: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module payload_power_sequencer_top_test;
    import pps_pkg::*;

    localparam int RAILS = RAIL_COUNT_DEF;
    localparam int REQ_W = $bits(in_item_t);
    localparam int unsigned CYCLE_LIMIT = 2000000;

    // message flag codes for directed requests
    localparam logic [4:0] MSG_NONE     = 5'b00000;
    localparam logic [4:0] MSG_QUIESCE  = 5'b10000;
    localparam logic [4:0] MSG_COLD     = 5'b01000;
    localparam logic [4:0] MSG_REBOOT   = 5'b00100;
    localparam logic [4:0] MSG_CLOCKCFG = 5'b00010;
    localparam logic [4:0] MSG_WRITE_OK = 5'b00001;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;

    // sequencer model state
    seq_state_t seq_state = ST_OFF;
    logic quiesce_pending = 1'b0;
    logic btn_prev = 1'b1;
    logic press_lock = 1'b0;
    logic [PRESS_W-1:0] press_count = '0;
    logic [RAIL_W-1:0] rails = '0;
    pins_t pins = '0;
    logic [ADC_W-1:0] pg_threshold = THRESHOLD_RST;
    logic [PRESS_W-1:0] press_limit = LONG_PRESS_RST;

    out_item_t pending_results[$];

    // bookkeeping
    int errors = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int rail_runs = 0;
    int soft_resets = 0;
    int config_writes = 0;
    logic [7:0] states_seen = '0;
    int unsigned cycle_count = 0;

    // sender and receiver pacing
    int burst_left = 0;
    bit no_gaps = 1'b0;
    logic btn_level = 1'b1;
    int hold_left = 0;
    int pattern_left = 0;
    logic [15:0] ready_pattern = '1;

    payload_power_sequencer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one control tick of the sequencer, queues the results it causes
    task automatic sequence_tick(input in_item_t req);
        seq_state_t st;
        events_t ev;
        run_t run;
        logic supply_ok;
        out_item_t res;
        int idx;
        ev = '0;
        run = RUN_NONE;

        // front button long press
        if (!req.button_level && btn_prev)
        begin
            press_count = '0;
            press_lock = 1'b0;
        end
        else if (press_count != PRESS_MAX)
        begin
            press_count++;
        end
        if (press_count > press_limit && !press_lock && !req.button_level)
        begin
            ev.soft_reset_pulse = 1'b1;
            press_lock = 1'b1;
        end
        btn_prev = req.button_level;

        // messages, clock request sees the state before cold reset
        st = seq_state;
        if (req.quiesce_msg)
            quiesce_pending = (st != ST_QUIESCED);
        if (req.clock_config_msg && st == ST_ON)
            ev.clock_write_request = 1'b1;
        if (req.cold_reset_msg)
            st = ST_RESET;
        if (req.reboot_msg)
            ev.soft_reset_pulse = 1'b1;
        if (ev.soft_reset_pulse)
            pins.reset_n = 1'b1;

        supply_ok = req.adc_sample > pg_threshold;

        // state update
        case (st)
            ST_OFF:
            begin
                if (supply_ok)
                    st = ST_GOOD_WAIT;
            end
            ST_GOOD_WAIT:
            begin
                if (!req.converters_good)
                    run = RUN_UP;
                ev.clear_backend_fault = 1'b1;
                if (quiesce_pending || !supply_ok)
                begin
                    st = ST_SWITCH_OFF;
                end
                else if (req.converters_good)
                begin
                    st = ST_SETUP;
                    pins.prog_b = 1'b1;
                    pins.init_b = 1'b1;
                    pins.reset_n = 1'b1;
                end
            end
            ST_SETUP:
            begin
                pins.fmc_power_good = 1'b1;
                ev.clock_write_request = 1'b1;
                if (req.clock_write_ok)
                    st = ST_ON;
            end
            ST_ON:
            begin
                if (quiesce_pending || !supply_ok || !req.converters_good)
                    st = ST_SWITCH_OFF;
            end
            ST_SWITCH_OFF:
            begin
                pins = '0;
                run = RUN_DOWN;
                if (quiesce_pending)
                begin
                    ev.quiesced_event = 1'b1;
                    quiesce_pending = 1'b0;
                end
                st = ST_QUIESCED;
            end
            ST_QUIESCED:
            begin
                if (!supply_ok && !req.converters_good)
                    st = ST_OFF;
            end
            ST_RESET:
            begin
                run = RUN_DOWN;
                st = ST_OFF;
            end
            default:
            begin
            end
        endcase
        seq_state = st;
        states_seen[st] = 1'b1;
        if (ev.soft_reset_pulse)
            soft_resets++;

        // results: one per rail step when the converters switch
        res.payload_state = st;
        res.fpga_reset_n = pins.reset_n;
        res.fpga_init_b = pins.init_b;
        res.fpga_program_b = pins.prog_b;
        res.fmc_power_good = pins.fmc_power_good;
        if (run == RUN_NONE)
        begin
            res.rail_enables = rails;
            res.last_of_run = 1'b1;
            {res.soft_reset_pulse, res.quiesced_event, res.clear_backend_fault,
             res.clock_write_request} = ev;
            pending_results.push_back(res);
        end
        else
        begin
            rail_runs++;
            for (int k = 0; k < RAILS; k++)
            begin
                idx = (run == RUN_UP) ? k : RAILS - 1 - k;
                rails[idx] = (run == RUN_UP);
                res.rail_enables = rails;
                res.last_of_run = (k == RAILS - 1);
                {res.soft_reset_pulse, res.quiesced_event, res.clear_backend_fault,
                 res.clock_write_request} = res.last_of_run ? ev : 4'b0000;
                pending_results.push_back(res);
            end
        end
    endtask

    // send one request, bursts with random gaps in between
    task automatic send_request(input in_item_t req);
        int gap;
        if (!no_gaps && burst_left == 0)
        begin
            gap = $urandom_range(6, 1);
            burst_left = $urandom_range(16, 1);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sequence_tick(req);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // sender pause until every result is back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // register write, only with the block idle
    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            CFG_THRESHOLD: pg_threshold = value[ADC_W-1:0];
            CFG_LONG_PRESS: press_limit = value;
            default:
            begin
            end
        endcase
        config_writes++;
    endtask

    function automatic in_item_t make_request(input logic [ADC_W-1:0] adc, input logic good,
                                              input logic btn, input logic [4:0] msgs);
        in_item_t r;
        r.adc_sample = adc;
        r.converters_good = good;
        r.button_level = btn;
        {r.quiesce_msg, r.cold_reset_msg, r.reboot_msg, r.clock_config_msg,
         r.clock_write_ok} = msgs;
        return r;
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    // supply sample on the wanted side of the threshold, edges now and then
    function automatic logic [ADC_W-1:0] pick_adc(input bit want_good);
        if (want_good && pg_threshold != '1)
        begin
            if (chance(15))
                return pg_threshold + 1'b1;
            return ADC_W'($urandom_range(4095, int'(pg_threshold) + 1));
        end
        if (!want_good)
        begin
            if (chance(15))
                return pg_threshold;
            return ADC_W'($urandom_range(int'(pg_threshold), 0));
        end
        return ADC_W'($urandom);
    endfunction

    // random request steered by the current state so that sequences go deep
    function automatic in_item_t next_request();
        in_item_t r;
        int good_pct;
        int dc_pct;
        int cc_pct;
        if (chance(10))
            return REQ_W'($urandom);
        if (chance(10))
            btn_level = ~btn_level;
        case (seq_state)
            ST_OFF:       begin good_pct = 80; dc_pct = 30; cc_pct = 10; end
            ST_GOOD_WAIT: begin good_pct = 90; dc_pct = 60; cc_pct = 10; end
            ST_SETUP:     begin good_pct = 90; dc_pct = 90; cc_pct = 10; end
            ST_ON:        begin good_pct = 90; dc_pct = 90; cc_pct = 40; end
            ST_QUIESCED:  begin good_pct = 40; dc_pct = 30; cc_pct = 10; end
            default:      begin good_pct = 50; dc_pct = 50; cc_pct = 10; end
        endcase
        r.adc_sample = pick_adc(chance(good_pct));
        r.converters_good = chance(dc_pct);
        r.button_level = btn_level;
        r.quiesce_msg = chance(5);
        r.cold_reset_msg = chance(3);
        r.reboot_msg = chance(4);
        r.clock_config_msg = chance(cc_pct);
        r.clock_write_ok = chance(50);
        return r;
    endfunction

    // receiver: long hold when asked, otherwise a rotating ready pattern
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            if (pattern_left == 0)
            begin
                case ($urandom_range(3, 0))
                    0: ready_pattern = '1;
                    1: ready_pattern = 16'($urandom);
                    2: ready_pattern = 16'($urandom | $urandom);
                    default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
                endcase
                pattern_left = 32;
            end
            out_ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
            pattern_left--;
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 200)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 200)
                    $display("%0t: result with no request waiting, expected none, actual %h",
                             $time, out_data);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                compare_field("payload_state", 16'(want.payload_state),
                              16'(out_data.payload_state));
                compare_field("rail_enables", 16'(want.rail_enables),
                              16'(out_data.rail_enables));
                compare_field("last_of_run", 16'(want.last_of_run),
                              16'(out_data.last_of_run));
                compare_field("fpga_reset_n", 16'(want.fpga_reset_n),
                              16'(out_data.fpga_reset_n));
                compare_field("fpga_init_b", 16'(want.fpga_init_b),
                              16'(out_data.fpga_init_b));
                compare_field("fpga_program_b", 16'(want.fpga_program_b),
                              16'(out_data.fpga_program_b));
                compare_field("fmc_power_good", 16'(want.fmc_power_good),
                              16'(out_data.fmc_power_good));
                compare_field("soft_reset_pulse", 16'(want.soft_reset_pulse),
                              16'(out_data.soft_reset_pulse));
                compare_field("quiesced_event", 16'(want.quiesced_event),
                              16'(out_data.quiesced_event));
                compare_field("clear_backend_fault", 16'(want.clear_backend_fault),
                              16'(out_data.clear_backend_fault));
                compare_field("clock_write_request", 16'(want.clock_write_request),
                              16'(out_data.clock_write_request));
            end
        end
    end

    // full power up and down, threshold edge, clock write handling
    task automatic test_power_cycle();
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_NONE));
        send_request(make_request(THRESHOLD_RST, 1'b0, 1'b1, MSG_NONE));
        send_request(make_request(THRESHOLD_RST + 1'b1, 1'b0, 1'b1, MSG_NONE));
        send_request(make_request(12'd4095, 1'b0, 1'b1, MSG_NONE));
        send_request(make_request(12'd3000, 1'b1, 1'b1, MSG_WRITE_OK));
        send_request(make_request(12'd3000, 1'b1, 1'b1, MSG_NONE));
        send_request(make_request(12'd3000, 1'b1, 1'b1, MSG_WRITE_OK));
        send_request(make_request(12'd3000, 1'b1, 1'b1, MSG_CLOCKCFG));
        send_request(make_request(12'd3000, 1'b1, 1'b1, MSG_WRITE_OK));
        send_request(make_request(12'd3000, 1'b0, 1'b1, MSG_NONE));
        send_request(make_request(12'd3000, 1'b0, 1'b1, MSG_NONE));
        send_request(make_request(12'd3000, 1'b0, 1'b1, MSG_NONE));
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_NONE));
    endtask

    // quiesce, reboot and cold reset messages
    task automatic test_messages();
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_QUIESCE));
        send_request(make_request(12'd4095, 1'b1, 1'b1, MSG_NONE));
        send_request(make_request(12'd4095, 1'b1, 1'b1, MSG_NONE));
        send_request(make_request(12'd4095, 1'b1, 1'b1, MSG_NONE));
        send_request(make_request(12'd4095, 1'b1, 1'b1, MSG_QUIESCE));
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_REBOOT));
        send_request(make_request(12'd4095, 1'b1, 1'b1, MSG_NONE));
        send_request(make_request(12'd4095, 1'b1, 1'b1, MSG_NONE));
        send_request(make_request(12'd4095, 1'b1, 1'b1, MSG_WRITE_OK));
        send_request(make_request(12'd4095, 1'b1, 1'b1, MSG_CLOCKCFG | MSG_COLD));
        send_request(make_request(12'd4095, 1'b1, 1'b0, 5'b11111));
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_NONE));
    endtask

    // long press fires once, lock until the next press
    task automatic test_long_press();
        write_register(CFG_LONG_PRESS, 16'd2);
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_NONE));
        repeat (5)
            send_request(make_request(12'd0, 1'b0, 1'b0, MSG_NONE));
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_NONE));
        repeat (4)
            send_request(make_request(12'd0, 1'b0, 1'b0, MSG_NONE));
        write_register(CFG_LONG_PRESS, 16'd0);
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_NONE));
        repeat (2)
            send_request(make_request(12'd0, 1'b0, 1'b0, MSG_NONE));
    endtask

    // limit at the counter top stays silent, a low limit fires on the held press
    task automatic test_press_top_limit();
        write_register(CFG_LONG_PRESS, PRESS_MAX);
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_COLD));
        repeat (8)
            send_request(make_request(12'd0, 1'b0, 1'b0, MSG_NONE));
        write_register(CFG_LONG_PRESS, 16'd1);
        send_request(make_request(12'd0, 1'b0, 1'b0, MSG_NONE));
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_NONE));
    endtask

    // receiver holds off while rail runs keep coming, input must stall
    task automatic test_backpressure();
        write_register(CFG_THRESHOLD, THRESHOLD_RST);
        write_register(CFG_LONG_PRESS, LONG_PRESS_RST);
        send_request(make_request(12'd0, 1'b0, 1'b1, MSG_COLD));
        send_request(make_request(12'd4095, 1'b0, 1'b1, MSG_NONE));
        wait_drained();
        no_gaps = 1'b1;
        hold_left = 150;
        repeat (10)
            send_request(make_request(12'd4095, 1'b0, 1'b1, MSG_NONE));
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // random traffic over several register settings, extremes included
    task automatic test_random_traffic();
        logic [ADC_W-1:0] thr;
        logic [PRESS_W-1:0] lim;
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin thr = THRESHOLD_RST; lim = 16'd6; end
                1: begin thr = '0; lim = '0; end
                2: begin thr = '1; lim = PRESS_MAX; end
                3: begin thr = ADC_W'($urandom); lim = PRESS_W'($urandom_range(12, 1)); end
                default: begin thr = ADC_W'($urandom_range(3500, 1000)); lim = 16'd3; end
            endcase
            write_register(CFG_THRESHOLD, {4'($urandom), thr});
            write_register(CFG_LONG_PRESS, lim);
            repeat (42)
                send_request(next_request());
        end
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_cycle();
        test_messages();
        test_long_press();
        test_press_top_limit();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (30)
            @(posedge clk);
        $display("run: %0d requests, %0d results checked, %0d rail runs, %0d soft resets",
                 requests_sent, results_checked, rail_runs, soft_resets);
        $display("run: states reached %b, %0d register writes", states_seen, config_writes);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
